[rtl/rbd_pkg.sv]
// Package for the ring buffer deque: sizes, action codes and transaction types.
package rbd_pkg;

  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int ACT_W = 3;

  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_QUERY      = 3'd4;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                     accepted;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;
    logic                     is_full;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
  } result_t;

endpackage

[rtl/ring_buffer_deque.sv]
// Ring buffer deque: push/pop at both ends of a fixed circular store in one RAM.
// Result: an accepted transaction moves the state through S_READ, where the RAM
//   read of the updated front and back is registered, to S_RESP, which raises done.
// A new start is taken in S_RESP while the result is shown, but not in S_READ,
//   which holds busy.
// Reset: rst (synchronous, active high) empties the deque; store contents are not cleared.
// The result is shown for exactly one cycle; the receiver cannot stall it.
module ring_buffer_deque (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  rbd_pkg::cmd_t   cmd,
  output logic            busy,
  output logic            done,
  output rbd_pkg::result_t result
);
  import rbd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W:0]   DEPTH_X  = (CNT_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

  // control state
  logic [1:0]       state, state_next;
  logic [IDX_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic             accepted, accepted_next;

  // RAM side
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  back_addr;
  logic [DATA_W-1:0] rdata_front, rdata_back;

  logic             take;
  logic             full, empty;
  logic [IDX_W-1:0] head_dec, head_inc, tail_addr;
  logic [CNT_W:0]   sum_tail, sum_back;

  assign full  = (count == DEPTH_C);
  assign empty = (count == '0);

  // Only the read of the new ends (S_READ) is locked out; S_IDLE and S_RESP take a start.
  assign busy = (state == S_READ);
  assign take = start && !busy;
  assign done = (state == S_RESP);

  // Index arithmetic with wraparound, valid for any DEPTH.
  assign head_dec = (head == '0) ? IDX_LAST : head - IDX_W'(1);
  assign head_inc = (head == IDX_LAST) ? '0 : head + IDX_W'(1);

  // slot one past the back (push back target)
  assign sum_tail  = (CNT_W + 1)'(head) + (CNT_W + 1)'(count);
  assign tail_addr = (sum_tail >= DEPTH_X) ? IDX_W'(sum_tail - DEPTH_X) : IDX_W'(sum_tail);

  // back element after the update; meaningless when empty (result masked)
  assign sum_back  = (CNT_W + 1)'(head) + (CNT_W + 1)'(count) - (CNT_W + 1)'(1);
  assign back_addr = (sum_back >= DEPTH_X) ? IDX_W'(sum_back - DEPTH_X) : IDX_W'(sum_back);

  // Action decode, applied at the accepting edge.
  always_comb begin
    head_next     = head;
    count_next    = count;
    accepted_next = accepted;
    we            = 1'b0;
    waddr         = head_dec;
    if (take) begin
      accepted_next = 1'b0;
      case (cmd.action)
        ACT_PUSH_FRONT: begin
          if (!full) begin
            head_next     = head_dec;
            waddr         = head_dec;
            we            = 1'b1;
            count_next    = count + CNT_W'(1);
            accepted_next = 1'b1;
          end
        end
        ACT_PUSH_BACK: begin
          if (!full) begin
            waddr         = tail_addr;
            we            = 1'b1;
            count_next    = count + CNT_W'(1);
            accepted_next = 1'b1;
          end
        end
        ACT_POP_FRONT: begin
          if (!empty) begin
            head_next     = head_inc;
            count_next    = count - CNT_W'(1);
            accepted_next = 1'b1;
          end
        end
        ACT_POP_BACK: begin
          if (!empty) begin
            count_next    = count - CNT_W'(1);
            accepted_next = 1'b1;
          end
        end
        ACT_QUERY: begin
          accepted_next = 1'b1;
        end
        default: begin
          accepted_next = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (take) state_next = S_READ;
      S_READ:  state_next = S_RESP;
      S_RESP:  state_next = take ? S_READ : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      count    <= '0;
      accepted <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      count    <= count_next;
      accepted <= accepted_next;
    end
  end

  // Writes happen only at the accept edge and reads in the following cycle,
  // so the read never races a write to the same entry.
  rbd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (cmd.value),
    .raddr0 (head),
    .raddr1 (back_addr),
    .rdata0 (rdata_front),
    .rdata1 (rdata_back)
  );

  // Result assembly; ends read as zero on an empty deque.
  always_comb begin
    result.accepted    = accepted;
    result.count       = count;
    result.is_empty    = empty;
    result.is_full     = full;
    result.front_value = empty ? '0 : rdata_front;
    result.back_value  = empty ? '0 : rdata_back;
  end

endmodule

[rtl/rbd_ram.sv]
// Generic RAM: one write port, two registered read ports.
module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr0,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr1,
  output logic [WIDTH-1:0]                 rdata0,
  output logic [WIDTH-1:0]                 rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule
